>>> rtl/int8_weight_dot_product_scaled_macros.svh
// Assertion helpers used by the checker file i8wdp_checker.sv
`ifndef INT8_WEIGHT_DOT_PRODUCT_SCALED_MACROS_SVH
`define INT8_WEIGHT_DOT_PRODUCT_SCALED_MACROS_SVH

`define I8WDP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`define I8WDP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define I8WDP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/i8wdp_pkg.sv
`default_nettype none
package i8wdp_pkg;
  localparam int Lanes    = 4;
  localparam int ActW     = 16;
  localparam int WtW      = 8;
  localparam int ProdW    = ActW + WtW;
  localparam int SumW     = ProdW + $clog2(Lanes) + 1;
  localparam int AccW     = 40;
  localparam int AccLoW   = 24;
  localparam int AccHiW   = AccW - AccLoW;
  localparam int MantW    = 16;
  localparam int ShiftW   = 6;
  localparam int PhiW     = AccHiW + MantW + 1;
  localparam int PloW     = AccLoW + MantW;
  localparam int FullW    = 64;
  localparam int OutW     = 32;
  localparam int InDataW  = Lanes * (ActW + WtW);
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegScaleMantissa = 2'd0;
  localparam logic [CfgIdxW-1:0] RegScaleShift    = 2'd1;

  localparam logic [MantW-1:0]  MantReset  = 16'd32768;
  localparam logic [ShiftW-1:0] ShiftReset = 6'd15;

  typedef struct packed {
    logic valid;
    logic last;
  } lane_ctl_t;

  typedef struct packed {
    logic                   valid;
    logic signed [AccW-1:0] acc;
  } acc_res_t;
endpackage
`default_nettype wire

>>> rtl/i8wdp_lane.sv
`default_nettype none
module i8wdp_lane (
  input  wire logic                                  clk_i,
  input  wire logic                                  en_i,
  input  wire logic signed [i8wdp_pkg::ActW-1:0]     act_i,
  input  wire logic signed [i8wdp_pkg::WtW-1:0]      wt_i,
  output logic signed [i8wdp_pkg::ProdW-1:0]         prod_o
);
  logic signed [i8wdp_pkg::ProdW-1:0] prod_d, prod_q;

  assign prod_d = i8wdp_pkg::ProdW'(act_i) * i8wdp_pkg::ProdW'(wt_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;
endmodule
`default_nettype wire

>>> rtl/i8wdp_accum.sv
`default_nettype none
module i8wdp_accum (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire i8wdp_pkg::lane_ctl_t                  ctl_i,
  input  wire logic signed [i8wdp_pkg::ProdW-1:0]    prod_i [i8wdp_pkg::Lanes],
  output i8wdp_pkg::acc_res_t                        res_o
);
  logic signed [i8wdp_pkg::SumW-1:0] sum;
  logic signed [i8wdp_pkg::AccW-1:0] total;
  logic signed [i8wdp_pkg::AccW-1:0] acc_d, acc_q;
  logic signed [i8wdp_pkg::AccW-1:0] res_acc_q;
  logic                              res_v_d, res_v_q;

  always_comb begin
    sum = '0;
    for (int i = 0; i < i8wdp_pkg::Lanes; i++) begin
      sum = sum + i8wdp_pkg::SumW'(prod_i[i]);
    end
  end

  assign total   = acc_q + i8wdp_pkg::AccW'(sum);
  assign res_v_d = ctl_i.valid && ctl_i.last;
  assign acc_d   = ctl_i.last ? '0 : total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      res_v_q <= 1'b0;
    end else if (en_i) begin
      res_v_q <= res_v_d;
      if (ctl_i.valid) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && res_v_d) begin
      res_acc_q <= total;
    end
  end

  assign res_o.valid = res_v_q;
  assign res_o.acc   = res_acc_q;
endmodule
`default_nettype wire

>>> rtl/i8wdp_scale.sv
`default_nettype none
module i8wdp_scale (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire i8wdp_pkg::acc_res_t                   res_i,
  input  wire logic [i8wdp_pkg::MantW-1:0]           mant_i,
  input  wire logic [i8wdp_pkg::ShiftW-1:0]          shift_i,
  output logic                                       valid_o,
  output logic [i8wdp_pkg::OutW-1:0]                 dot_o,
  output logic                                       sat_o
);
  localparam int SatW = i8wdp_pkg::FullW - i8wdp_pkg::OutW + 1;

  logic signed [i8wdp_pkg::PhiW-1:0]  phi_d, phi_q;
  logic [i8wdp_pkg::PloW-1:0]         plo_d, plo_q;
  logic                               v1_q, v2_q, out_v_q;
  logic signed [i8wdp_pkg::FullW-1:0] full, rnd, rnd_d, rnd_q, shifted;
  logic [SatW-1:0]                    top_bits;
  logic                               sat_d;
  logic [i8wdp_pkg::OutW-1:0]         dot_d;
  logic [i8wdp_pkg::OutW-1:0]         dot_q;
  logic                               sat_q;

  assign phi_d = $signed(res_i.acc[i8wdp_pkg::AccW-1:i8wdp_pkg::AccLoW])
               * $signed({1'b0, mant_i});
  assign plo_d = i8wdp_pkg::PloW'(res_i.acc[i8wdp_pkg::AccLoW-1:0]) * i8wdp_pkg::PloW'(mant_i);

  assign full  = (i8wdp_pkg::FullW'(phi_q) <<< i8wdp_pkg::AccLoW)
               + $signed(i8wdp_pkg::FullW'(plo_q));
  assign rnd   = (shift_i == '0) ? '0
               : $signed(i8wdp_pkg::FullW'(1) << (shift_i - i8wdp_pkg::ShiftW'(1)));
  assign rnd_d = full + rnd;

  assign shifted  = rnd_q >>> shift_i;
  assign top_bits = shifted[i8wdp_pkg::FullW-1:i8wdp_pkg::OutW-1];
  assign sat_d    = !((top_bits == '0) || (top_bits == '1));
  assign dot_d    = !sat_d ? shifted[i8wdp_pkg::OutW-1:0]
                  : (shifted[i8wdp_pkg::FullW-1] ? {1'b1, {(i8wdp_pkg::OutW-1){1'b0}}}
                                                 : {1'b0, {(i8wdp_pkg::OutW-1){1'b1}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v1_q    <= res_i.valid;
      v2_q    <= v1_q;
      out_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (res_i.valid) begin
        phi_q <= phi_d;
        plo_q <= plo_d;
      end
      if (v1_q) begin
        rnd_q <= rnd_d;
      end
      if (v2_q) begin
        dot_q <= dot_d;
        sat_q <= sat_d;
      end
    end
  end

  assign valid_o = out_v_q;
  assign dot_o   = dot_q;
  assign sat_o   = sat_q;
endmodule
`default_nettype wire

>>> rtl/int8_weight_dot_product_scaled.sv
// Int8-weight dot-product engine with fixed-point dequantization.
// Input stream (s_axis): one beat carries four Q8.8 activations and four int8
// weights; tlast marks the final beat of a row. Each beat's lane products are
// summed into a 40-bit accumulator; beats without tlast produce no output.
// Output stream (m_axis): one beat per row, the accumulator times
// scale_mantissa, shifted right by scale_shift with round-half-up, saturated
// to 32 bits; tuser flags saturation.
// Throughput: one input beat per cycle unless stalled; four lane multipliers
// work in parallel and only the accumulator add loops back between beats.
// Pipeline: the row result is registered after lane multiply, accumulate,
// split scale multiply, round, and shift/saturate, in that order.
// Stall: the whole pipeline holds while an output beat waits; s_axis_tready
// drops in that case and rises again in the cycle m_axis_tready is high.
// Reset: accumulator cleared, pipeline empty, scale_mantissa = 32768 and
// scale_shift = 15 (unity scale). Write the scale registers only while idle.
`default_nettype none
module int8_weight_dot_product_scaled (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [i8wdp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [i8wdp_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // act_0, act_1, act_2, act_3, wt_0, wt_1, wt_2, wt_3
  input  wire logic [i8wdp_pkg::InDataW-1:0]       s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // dot_value
  output logic [i8wdp_pkg::OutW-1:0]               m_axis_tdata,
  // saturated
  output logic                                     m_axis_tuser
);
  logic [i8wdp_pkg::MantW-1:0]        mant_q;
  logic [i8wdp_pkg::ShiftW-1:0]       shift_q;
  logic                               en;
  i8wdp_pkg::lane_ctl_t               ctl_d, ctl_q;
  logic signed [i8wdp_pkg::ProdW-1:0] prod [i8wdp_pkg::Lanes];
  i8wdp_pkg::acc_res_t                res;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign ctl_d.valid   = s_axis_tvalid;
  assign ctl_d.last    = s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mant_q  <= i8wdp_pkg::MantReset;
      shift_q <= i8wdp_pkg::ShiftReset;
      ctl_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          i8wdp_pkg::RegScaleMantissa: mant_q <= cfg_wdata_i[i8wdp_pkg::MantW-1:0];
          i8wdp_pkg::RegScaleShift:    shift_q <= cfg_wdata_i[i8wdp_pkg::ShiftW-1:0];
          default: ;
        endcase
      end
      if (en) begin
        ctl_q <= ctl_d;
      end
    end
  end

  for (genvar g = 0; g < i8wdp_pkg::Lanes; g++) begin : g_lane
    i8wdp_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .act_i  ($signed(s_axis_tdata[g*i8wdp_pkg::ActW +: i8wdp_pkg::ActW])),
      .wt_i   ($signed(s_axis_tdata[i8wdp_pkg::Lanes*i8wdp_pkg::ActW + g*i8wdp_pkg::WtW
                                    +: i8wdp_pkg::WtW])),
      .prod_o (prod[g])
    );
  end

  i8wdp_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl_q),
    .prod_i (prod),
    .res_o  (res)
  );

  i8wdp_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .res_i   (res),
    .mant_i  (mant_q),
    .shift_i (shift_q),
    .valid_o (m_axis_tvalid),
    .dot_o   (m_axis_tdata),
    .sat_o   (m_axis_tuser)
  );
endmodule
`default_nettype wire

>>> rtl/i8wdp_checker.sv
`default_nettype none
`include "int8_weight_dot_product_scaled_macros.svh"
module i8wdp_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [i8wdp_pkg::OutW-1:0]     m_axis_tdata,
  input wire logic                           m_axis_tuser
);
  `I8WDP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `I8WDP_ASSERT_IMP(a_stall_blocks_in, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `I8WDP_ASSERT_IMP(a_sat_at_limit, m_axis_tvalid && m_axis_tuser, (m_axis_tdata == 32'h7fff_ffff) || (m_axis_tdata == 32'h8000_0000))
  `I8WDP_ASSERT(a_idle_after_reset, $rose(rst_ni) |-> !m_axis_tvalid)
endmodule

bind int8_weight_dot_product_scaled i8wdp_checker u_i8wdp_checker (.*);
`default_nettype wire

>>> dv/tb_int8_weight_dot_product_scaled.sv
module tb_int8_weight_dot_product_scaled;
  timeunit 1ns;
  timeprecision 1ps;

  import i8wdp_pkg::*;

  localparam int DrainCycles = 8;
  localparam int StuckLimit  = 2000;
  localparam int LongRowLen  = 48;
  localparam int PhaseItems  = 85;

  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;

  typedef struct {
    logic [InDataW-1:0] data;
    logic               last;
  } lane_group_t;

  typedef struct {
    logic [OutW-1:0] dot;
    logic            sat;
  } dot_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // act_0, act_1, act_2, act_3, wt_0, wt_1, wt_2, wt_3
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // dot_value
  logic [OutW-1:0]     m_axis_tdata;
  // saturated
  logic                m_axis_tuser;

  lane_group_t lane_group_q[$];
  dot_res_t    dot_expect_q[$];

  logic [AccW-1:0]   row_acc     = '0;
  logic [MantW-1:0]  scale_mant  = MantReset;
  logic [ShiftW-1:0] scale_shift = ShiftReset;

  int mismatch_count = 0;
  int stuck_cycles   = 0;
  bit in_taken       = 1'b0;
  int burst_left     = 0;
  int gap_left       = 0;
  int ready_pct      = 100;
  int pattern_left   = 0;

  int8_weight_dot_product_scaled u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [OutW-1:0] got,
                                 input logic [OutW-1:0] want);
    $display("%0t mismatch %s: got 0x%08h want 0x%08h", $time, what, got, want);
    mismatch_count++;
  endtask

  // accumulate one lane group, and scale/round/saturate at the end of a row
  task automatic accumulate_beat(input logic [InDataW-1:0] d, input logic last);
    logic signed [63:0] lane_sum;
    logic signed [63:0] a;
    logic signed [63:0] w;
    logic signed [63:0] acc_s;
    logic signed [63:0] prod;
    logic signed [63:0] rounded;
    dot_res_t res;
    lane_sum = '0;
    for (int i = 0; i < Lanes; i++) begin
      a = $signed(d[i*ActW +: ActW]);
      w = $signed(d[Lanes*ActW + i*WtW +: WtW]);
      lane_sum += a * w;
    end
    row_acc = row_acc + lane_sum[AccW-1:0];
    if (last) begin
      acc_s = $signed(row_acc);
      prod = acc_s * $signed({48'd0, scale_mant});
      if (scale_shift != 0) prod = prod + (64'sd1 <<< (scale_shift - 1));
      rounded = prod >>> scale_shift;
      if (rounded > 64'sh7FFF_FFFF) begin
        res.dot = 32'h7FFF_FFFF;
        res.sat = 1'b1;
      end else if (rounded < -64'sh8000_0000) begin
        res.dot = 32'h8000_0000;
        res.sat = 1'b1;
      end else begin
        res.dot = rounded[OutW-1:0];
        res.sat = 1'b0;
      end
      dot_expect_q.push_back(res);
      row_acc = '0;
    end
  endtask

  task automatic push_group(input logic [Lanes-1:0][ActW-1:0] act,
                            input logic [Lanes-1:0][WtW-1:0] wt, input logic last);
    lane_group_t g;
    g.data = {wt, act};
    g.last = last;
    lane_group_q.push_back(g);
  endtask

  task automatic push_uniform(input logic [ActW-1:0] act, input logic [WtW-1:0] wt,
                              input logic last);
    push_group({Lanes{act}}, {Lanes{wt}}, last);
  endtask

  function automatic logic [ActW-1:0] rand_act();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [WtW-1:0] rand_wt();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_rows(input int n_items);
    logic [Lanes-1:0][ActW-1:0] act;
    logic [Lanes-1:0][WtW-1:0]  wt;
    int added;
    int len;
    added = 0;
    while (added < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int j = 0; j < len; j++) begin
        for (int i = 0; i < Lanes; i++) begin
          act[i] = rand_act();
          wt[i]  = rand_wt();
        end
        push_group(act, wt, j == len - 1);
      end
      added += len;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      RegScaleMantissa: scale_mant  = val;
      RegScaleShift:    scale_shift = val[ShiftW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_scale(input logic [CfgDataW-1:0] mant, input logic [CfgDataW-1:0] shift);
    write_reg(RegScaleMantissa, mant);
    write_reg(RegScaleShift, shift);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (lane_group_q.size() != 0 || s_axis_tvalid || dot_expect_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      accumulate_beat(s_axis_tdata, s_axis_tlast);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin : driver
    lane_group_t g;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (lane_group_q.size() > 0) begin
        g = lane_group_q.pop_front();
        s_axis_tdata  <= g.data;
        s_axis_tlast  <= g.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 10);
          case ($urandom_range(0, 7))
            0, 1:    gap_left = 0;
            2:       gap_left = $urandom_range(20, 30);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pct = 100;
        1:       ready_pct = 75;
        2:       ready_pct = 40;
        default: ready_pct = 10;
      endcase
      pattern_left = $urandom_range(16, 128);
    end
    pattern_left--;
    m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk_i) begin : monitor
    dot_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (dot_expect_q.size() == 0) begin
        report_mismatch("unexpected result beat", m_axis_tdata, '0);
      end else begin
        want = dot_expect_q.pop_front();
        if (m_axis_tdata !== want.dot) report_mismatch("dot_value", m_axis_tdata, want.dot);
        if (m_axis_tuser !== want.sat)
          report_mismatch("saturated", 32'(m_axis_tuser), 32'(want.sat));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stim
    logic [CfgDataW-1:0] mant_set[8];
    logic [CfgDataW-1:0] shift_set[8];
    mant_set  = '{16'd32768, 16'd65535, 16'd0, 16'd1, 16'd65535, 16'd40000, 16'd0, 16'd65535};
    shift_set = '{16'd15, 16'd0, 16'd7, 16'd47, 16'd63, 16'hFFB0, 16'd0, 16'd20};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // unity scale: lane extremes, zero row, short row, plus and minus one
    push_uniform(16'h7FFF, 8'h7F, 1'b1);
    push_uniform(16'h8000, 8'h80, 1'b1);
    push_uniform(16'h8000, 8'h7F, 1'b1);
    push_uniform(16'h7FFF, 8'h80, 1'b1);
    push_uniform(16'h0000, 8'h00, 1'b1);
    push_group({16'h0000, 16'h0100, 16'hFF00, 16'h1234}, {8'h01, 8'h7F, 8'h80, 8'hFE}, 1'b0);
    push_group({16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF}, {8'h80, 8'h80, 8'h7F, 8'h01}, 1'b0);
    push_uniform(16'h0100, 8'h02, 1'b1);
    push_group({16'h0000, 16'h0000, 16'h0000, 16'h0001}, {8'h00, 8'h00, 8'h00, 8'h01}, 1'b1);
    push_group({16'h0000, 16'h0000, 16'h0000, 16'hFFFF}, {8'h00, 8'h00, 8'h00, 8'h01}, 1'b1);
    wait_idle();

    // ties round toward plus infinity
    set_scale(16'd1, 16'd1);
    push_group({16'h0000, 16'h0000, 16'h0000, 16'h0001}, {8'h00, 8'h00, 8'h00, 8'h01}, 1'b1);
    push_group({16'h0000, 16'h0000, 16'h0000, 16'hFFFF}, {8'h00, 8'h00, 8'h00, 8'h01}, 1'b1);
    push_group({16'h0000, 16'h0000, 16'h0000, 16'h0003}, {8'h00, 8'h00, 8'h00, 8'h01}, 1'b1);
    push_group({16'h0000, 16'h0000, 16'h0000, 16'hFFFD}, {8'h00, 8'h00, 8'h00, 8'h01}, 1'b1);
    wait_idle();

    // saturate both ways, no rounding term
    set_scale(16'd65535, 16'd0);
    push_uniform(16'h8000, 8'h80, 1'b0);
    push_uniform(16'h8000, 8'h80, 1'b1);
    push_uniform(16'h7FFF, 8'h80, 1'b0);
    push_uniform(16'h7FFF, 8'h80, 1'b1);
    wait_idle();

    // spare indexes must not disturb the scale
    write_reg(RegSpare2, 16'hFFFF);
    write_reg(RegSpare3, 16'($urandom_range(0, 65535)));
    push_uniform(16'h8000, 8'h80, 1'b1);
    wait_idle();

    for (int k = 0; k < 8; k++) begin
      if (k == 6) set_scale(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 63)));
      else set_scale(mant_set[k], shift_set[k]);
      if (k == 3) begin
        write_reg(RegSpare2, 16'($urandom_range(0, 65535)));
        write_reg(RegSpare3, 16'hFFFF);
      end
      add_rows(PhaseItems);
      wait_idle();
    end

    // long row of extreme products at unity scale
    set_scale(16'd32768, 16'd15);
    for (int n = 0; n < LongRowLen; n++) push_uniform(16'h8000, 8'h80, n == LongRowLen - 1);
    push_uniform(16'h0100, 8'h03, 1'b1);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/i8wdp_pkg.sv
rtl/i8wdp_lane.sv
rtl/i8wdp_accum.sv
rtl/i8wdp_scale.sv
rtl/int8_weight_dot_product_scaled.sv
rtl/i8wdp_checker.sv
dv/tb_int8_weight_dot_product_scaled.sv
